>>> src/char_fifo_token_reader_top_macros.svh
// Assertion macros shared by the character FIFO token reader.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CHAR_FIFO_TOKEN_READER_TOP_MACROS_SVH
`define CHAR_FIFO_TOKEN_READER_TOP_MACROS_SVH

// Same-cycle check: whenever the antecedent holds, the consequent holds too.
`define CFTR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: the consequent holds in the cycle after the antecedent.
`define CFTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cftr_pkg.sv
// Shared types, codes and character helpers for the character FIFO token reader.
// Has no dependencies; used by cftr_buf and char_fifo_token_reader_top.
package cftr_pkg;

    // Action codes of an input transaction.
    localparam logic [1:0] ACT_PUSH      = 2'd0;
    localparam logic [1:0] ACT_EOL       = 2'd1;
    localparam logic [1:0] ACT_READ_CHAR = 2'd2;
    localparam logic [1:0] ACT_READ_INT  = 2'd3;

    // Status codes of a result transaction.
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_DROPPED = 2'd1;
    localparam logic [1:0] STS_NONE    = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHR_TAB     = 8'h09;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] RADIX       = 8'd10;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // Command from the sequencer to the character store.
    typedef struct packed {
        logic       push;
        logic [7:0] push_data;
        logic       pop;
    } t_buf_cmd;

    // Status from the character store back to the sequencer.
    typedef struct packed {
        logic       full;
        logic       no_nonblank;
        logic       one_left;
        logic [7:0] rd_data;
    } t_buf_stat;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHR_SPACE) || (c == CHR_NEWLINE) || (c == CHR_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHR_ZERO) && (c <= CHR_NINE);
    endfunction

endpackage

>>> src/char_fifo_token_reader_top.sv
// Character FIFO with token reads: usage notes.
// Input channel (i_in_valid / o_in_stall) carries i_action and i_char_in; an
// input transaction completes on a clock edge with valid high and stall low.
// Output channel (o_out_valid / i_out_stall) carries o_value and o_status; one
// result transaction is produced for every input transaction, in order.
// Push and end-of-line skip the scan and go straight to the result; the next
// input is taken as soon as the result has moved to the output register.
// A read examines the stored bytes it needs one by one: the single memory read
// port delivers one entry per cycle to the scan loop.
// A read with nothing but blanks held answers at once with status "none".
// Reset (i_rst_n low, synchronous) empties the store and clears both channels;
// stored bytes are not cleared and are never read before being written.
// While the receiver stalls, the result stays in the output register and one
// further finished result waits inside; input is then held off.
// Depends on cftr_pkg, cftr_buf and the macro header.
`include "char_fifo_token_reader_top_macros.svh"

module char_fifo_token_reader_top import cftr_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_value,
    output logic [1:0] o_status
);

    t_state     r_state,  n_state;
    logic       r_mode_int, n_mode_int;
    logic       r_in_digits, n_in_digits;
    logic [7:0] r_acc, n_acc;
    logic [7:0] r_res_value, n_res_value;
    logic [1:0] r_res_status, n_res_status;
    logic       r_out_valid;
    logic [7:0] r_out_value;
    logic [1:0] r_out_status;

    t_buf_cmd   cmd;
    t_buf_stat  stat;
    logic       in_accept;
    logic       out_free;
    logic [7:0] ch;
    logic [7:0] digit_val;
    logic [7:0] acc_next;

    cftr_buf #(
        .DEPTH (DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Decimal accumulation of the byte under the read pointer.
    assign ch        = stat.rd_data;
    assign digit_val = ch - CHR_ZERO;
    assign acc_next  = (r_acc << 3) + (r_acc << 1) + digit_val;

    // Sequencer: accept, scan one entry per cycle on a read, then hand off the result.
    always_comb begin
        n_state      = r_state;
        n_mode_int   = r_mode_int;
        n_in_digits  = r_in_digits;
        n_acc        = r_acc;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        cmd          = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_res_value  = '0;
                    n_res_status = STS_OK;
                    if ((i_action == ACT_PUSH) || (i_action == ACT_EOL)) begin
                        n_state = ST_DONE;
                        if (stat.full) begin
                            n_res_status = STS_DROPPED;
                        end else begin
                            cmd.push      = 1'b1;
                            cmd.push_data = (i_action == ACT_PUSH) ? i_char_in : CHR_SPACE;
                        end
                    end else if (stat.no_nonblank) begin
                        n_state      = ST_DONE;
                        n_res_status = STS_NONE;
                    end else begin
                        n_state     = ST_SCAN;
                        n_mode_int  = (i_action == ACT_READ_INT);
                        n_in_digits = 1'b0;
                        n_acc       = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (!r_mode_int) begin
                    // Read char: drop blanks, return the first other byte.
                    cmd.pop = 1'b1;
                    if (!is_blank(ch)) begin
                        n_res_value = ch;
                        n_state     = ST_DONE;
                    end
                end else if (!r_in_digits) begin
                    // Read integer, skipping non-digits until a digit shows up.
                    cmd.pop = 1'b1;
                    if (is_digit(ch)) begin
                        n_in_digits = 1'b1;
                        n_acc       = digit_val;
                    end
                    if (stat.one_left) begin
                        n_res_value = is_digit(ch) ? digit_val : 8'd0;
                        n_state     = ST_DONE;
                    end
                end else if (is_digit(ch)) begin
                    // Gathering digits.
                    cmd.pop = 1'b1;
                    n_acc   = acc_next;
                    if (stat.one_left) begin
                        n_res_value = acc_next;
                        n_state     = ST_DONE;
                    end
                end else begin
                    // First non-digit ends the number and stays stored.
                    n_res_value = r_acc;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode_int   <= n_mode_int;
        r_in_digits  <= n_in_digits;
        r_acc        <= n_acc;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
    end

    // Output register: loaded from the finished result when free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;

    // A held result is not overwritten while the receiver stalls.
    `CFTR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_value), "stalled result changed")
    // Scanning only starts when a non-blank byte is held.
    `CFTR_ASSERT_NOW(a_scan_nonempty, r_state == ST_SCAN && !r_mode_int, !stat.no_nonblank, "char scan with no non-blank byte")
    // Failure statuses always carry a zero value.
    `CFTR_ASSERT_NOW(a_fail_zero, r_state == ST_DONE && r_res_status != STS_OK, r_res_value == 8'd0, "failure with nonzero value")

endmodule

>>> src/cftr_buf.sv
// Character store of the token reader: a one-port-write, registered-read memory
// with its ring pointers and counters. Depends on cftr_pkg and the macro header.
`include "char_fifo_token_reader_top_macros.svh"

module cftr_buf import cftr_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_buf_cmd  i_cmd,
    output t_buf_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_rp;
    logic [AW-1:0] r_wp;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_nonblank;

    logic [AW-1:0] n_rp;
    logic [AW-1:0] rp_inc;
    logic [AW-1:0] wp_inc;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] n_fill;
    logic [CW-1:0] n_nonblank;

    // Ring increments wrap at the last entry.
    assign rp_inc = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign wp_inc = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp   = i_cmd.pop ? rp_inc : r_rp;

    // The read port always looks at the oldest entry after this cycle's pop.
    assign rd_addr = n_rp;

    // Memory: write on push, registered read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wp] <= i_cmd.push_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Counter updates for push and pop.
    always_comb begin
        n_fill     = r_fill;
        n_nonblank = r_nonblank;
        if (i_cmd.push) begin
            n_fill = n_fill + 1'b1;
            if (!is_blank(i_cmd.push_data)) begin
                n_nonblank = n_nonblank + 1'b1;
            end
        end
        if (i_cmd.pop) begin
            n_fill = n_fill - 1'b1;
            if (!is_blank(r_rd_data) && (r_nonblank != '0)) begin
                n_nonblank = n_nonblank - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp       <= '0;
            r_wp       <= '0;
            r_fill     <= '0;
            r_nonblank <= '0;
        end else begin
            r_rp       <= n_rp;
            r_fill     <= n_fill;
            r_nonblank <= n_nonblank;
            if (i_cmd.push) begin
                r_wp <= wp_inc;
            end
        end
    end

    assign o_stat.full        = (r_fill == CW'(DEPTH));
    assign o_stat.no_nonblank = (r_nonblank == '0);
    assign o_stat.one_left    = (r_fill == CW'(1));
    assign o_stat.rd_data     = r_rd_data;

    // The sequencer never pushes and pops in the same cycle.
    `CFTR_ASSERT_NOW(a_push_pop_excl, i_cmd.push, !i_cmd.pop, "push and pop together")
    // A push is only issued while there is room.
    `CFTR_ASSERT_NOW(a_push_room, i_cmd.push, r_fill != CW'(DEPTH), "push into full store")
    // A pop is only issued while an entry is held.
    `CFTR_ASSERT_NOW(a_pop_held, i_cmd.pop, r_fill != '0, "pop from empty store")
    // Non-blank entries are a subset of the held entries.
    `CFTR_ASSERT_NOW(a_nb_le_fill, 1'b1, r_nonblank <= r_fill, "non-blank count above fill")

endmodule
